// ===== rtl/core/servo_ramp_pulse_generator_macros.svh =====
// Assertion shorthands for the servo ramp block.
// Both expect clk and rst_n to be visible where they are used.
`ifndef SERVO_RAMP_PULSE_GENERATOR_MACROS_SVH
`define SERVO_RAMP_PULSE_GENERATOR_MACROS_SVH

// same-cycle implication
`define SRPG_HOLDS(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srpg check failed");

// next-cycle implication
`define SRPG_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srpg check failed");

`endif

// ===== rtl/core/srpg_pkg.sv =====
`timescale 1ns / 1ps

package srpg_pkg;

    localparam int ELAPSED_W  = 32;
    localparam int ANGLE_W    = 16;
    localparam int VEL_W      = 16;
    localparam int PULSE_W    = 16;
    localparam int MS_W       = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // velocity * elapsed
    localparam int PROD_W  = ELAPSED_W + VEL_W;
    // shared signed multiplier
    localparam int MUL_W   = 18;
    localparam int MPROD_W = 2 * MUL_W;
    localparam int CMP_W   = (PROD_W > MPROD_W) ? PROD_W : MPROD_W;
    // both the shift-add multiply and the divider run 16 steps
    localparam int STEPS   = VEL_W;
    localparam int STEP_W  = $clog2(STEPS);

    // floor(x / 1000) = (x * ceil(2^36 / 1000)) >> 36, exact for x < 2^26
    localparam int DIVX_W   = 26;
    localparam int RECIP_W  = 27;
    localparam int RECIP_SH = 36;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic        [VEL_W-1:0]   vel_t;
    typedef logic signed [VEL_W-1:0]   vel_in_t;
    typedef logic        [PULSE_W-1:0] pulse_t;
    typedef logic        [MS_W-1:0]    ms_t;

    localparam logic [PULSE_W-1:0] MS_PER_S  = PULSE_W'(1000);
    localparam logic [RECIP_W-1:0] MS_RECIP  = RECIP_W'(68719477);
    localparam vel_t               VEL_FLOOR = VEL_W'(410);

    localparam angle_t MIN_ANGLE_RST = -16'sd6434;
    localparam angle_t MAX_ANGLE_RST = 16'sd6434;
    localparam pulse_t MIN_PULSE_RST = 16'd1000;
    localparam pulse_t MAX_PULSE_RST = 16'd2000;
    localparam vel_t   MAX_VEL_RST   = 16'd4096;
    localparam angle_t HOME_RST      = 16'sd0;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_TARGET   = 2'd1,
        OP_VELOCITY = 2'd2,
        OP_HOLD     = 2'd3
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_ANGLE    = 3'd0,
        CFG_MAX_ANGLE    = 3'd1,
        CFG_MIN_PULSE    = 3'd2,
        CFG_MAX_PULSE    = 3'd3,
        CFG_MAX_VELOCITY = 3'd4,
        CFG_HOME_ANGLE   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        angle_t min_angle;
        angle_t max_angle;
        pulse_t min_pulse;
        pulse_t max_pulse;
        vel_t   max_velocity;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_CMP,
        DP_DIV_STEP,
        DP_MOVE,
        DP_MAP_MUL1,
        DP_MAP_MUL2,
        DP_MAP_SUM,
        DP_MAP_FIX,
        DP_MAP_EVAL,
        DP_PULSE,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic snap;
        logic map_special;
    } dp_stat_t;

endpackage

// ===== rtl/core/srpg_if.sv =====
`timescale 1ns / 1ps

interface srpg_req_if;
    import srpg_pkg::*;

    logic    valid;
    logic    ready;
    logic [1:0] op;
    ms_t     delta_ms;
    angle_t  target_angle_in;
    vel_in_t velocity_in;

    modport source (output valid, output op, output delta_ms, output target_angle_in,
                    output velocity_in, input ready);
    modport sink   (input valid, input op, input delta_ms, input target_angle_in,
                    input velocity_in, output ready);
endinterface

interface srpg_rsp_if;
    import srpg_pkg::*;

    logic   valid;
    logic   ready;
    pulse_t pulse_us;
    angle_t angle_now;
    logic   at_target;

    modport source (output valid, output pulse_us, output angle_now, output at_target,
                    input ready);
    modport sink   (input valid, input pulse_us, input angle_now, input at_target,
                    output ready);
endinterface

// ===== rtl/core/srpg_cfg.sv =====
`timescale 1ns / 1ps

module srpg_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_en,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output srpg_pkg::cfg_t                    cfg
);
    import srpg_pkg::*;

    angle_t min_angle_reg;
    angle_t max_angle_reg;
    pulse_t min_pulse_reg;
    pulse_t max_pulse_reg;
    vel_t   max_vel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg <= MIN_ANGLE_RST;
            max_angle_reg <= MAX_ANGLE_RST;
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            max_vel_reg   <= MAX_VEL_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MIN_ANGLE:    min_angle_reg <= ANGLE_W'(cfg_data);
                CFG_MAX_ANGLE:    max_angle_reg <= ANGLE_W'(cfg_data);
                CFG_MIN_PULSE:    min_pulse_reg <= PULSE_W'(cfg_data);
                CFG_MAX_PULSE:    max_pulse_reg <= PULSE_W'(cfg_data);
                CFG_MAX_VELOCITY: max_vel_reg   <= VEL_W'(cfg_data);
                // home angle only acts through reset, where it holds its reset value
                CFG_HOME_ANGLE:   ;
                default:          ;
            endcase
        end
    end

    assign cfg.min_angle    = min_angle_reg;
    assign cfg.max_angle    = max_angle_reg;
    assign cfg.min_pulse    = min_pulse_reg;
    assign cfg.max_pulse    = max_pulse_reg;
    assign cfg.max_velocity = max_vel_reg;

endmodule

// ===== rtl/core/srpg_dpath.sv =====
`timescale 1ns / 1ps

module srpg_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srpg_pkg::dp_cmd_t    cmd,
    output srpg_pkg::dp_stat_t   stat,
    input  srpg_pkg::cfg_t       cfg,
    input  logic [1:0]           op,
    input  srpg_pkg::ms_t        delta_ms,
    input  srpg_pkg::angle_t     target_angle_in,
    input  srpg_pkg::vel_in_t    velocity_in,
    output srpg_pkg::pulse_t     pulse_us,
    output srpg_pkg::angle_t     angle_now,
    output logic                 at_target
);
    import srpg_pkg::*;

    // motion state
    angle_t                 start_reg;
    angle_t                 cur_reg;
    angle_t                 goal_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    vel_t                   vel_reg;

    // scratch
    logic [PROD_W-1:0]          acc_reg;
    logic [PROD_W-1:0]          mcand_reg;
    vel_t                       mplier_reg;
    logic signed [MPROD_W-1:0]  prod_reg;
    logic signed [MPROD_W-1:0]  num_reg;
    logic [PULSE_W-1:0]         rem_reg;
    logic [PULSE_W-1:0]         quo_reg;
    logic [PULSE_W-1:0]         dvsr_reg;
    pulse_t                     pulse_tmp_reg;

    // result word
    pulse_t pulse_out_reg;
    angle_t angle_out_reg;
    logic   at_tgt_reg;

    logic [ELAPSED_W:0]         elapsed_sum;
    logic [ELAPSED_W-1:0]       elapsed_sat;
    logic signed [VEL_W:0]      vel_req;
    logic signed [VEL_W:0]      vel_cap;
    vel_t                       vel_clamped;
    logic signed [ANGLE_W:0]    span_diff;
    logic [ANGLE_W-1:0]         span_abs;
    logic [ANGLE_W:0]           span_p1;
    logic                       goal_up;
    logic signed [ANGLE_W:0]    den;
    logic [ANGLE_W-1:0]         den_abs;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [MPROD_W-1:0]  mul_p;
    logic                       snap;
    logic [DIVX_W+RECIP_W-1:0]  recip_p;
    logic [PULSE_W-1:0]         dist_q;
    logic [MPROD_W-17:0]        num_hi;
    logic                       num_neg;
    logic                       num_over;
    logic [PULSE_W:0]           trial;
    logic                       fits;
    logic [PULSE_W-1:0]         rem_step;
    logic signed [ANGLE_W:0]    q_ext;
    logic signed [ANGLE_W:0]    move_val;

    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(delta_ms);
        elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

        vel_req = (VEL_W+1)'(velocity_in);
        vel_cap = $signed({1'b0, cfg.max_velocity});
        if (vel_req > vel_cap)
            vel_clamped = cfg.max_velocity;
        else if (vel_req <= 0)
            vel_clamped = VEL_FLOOR;
        else
            vel_clamped = velocity_in[VEL_W-1:0];

        span_diff = (ANGLE_W+1)'(goal_reg) - (ANGLE_W+1)'(start_reg);
        span_abs  = span_diff[ANGLE_W] ? ANGLE_W'(-span_diff) : span_diff[ANGLE_W-1:0];
        span_p1   = {1'b0, span_abs} + (ANGLE_W+1)'(1);
        goal_up   = goal_reg > start_reg;

        den     = (ANGLE_W+1)'(cfg.max_angle) - (ANGLE_W+1)'(cfg.min_angle);
        den_abs = den[ANGLE_W] ? ANGLE_W'(-den) : den[ANGLE_W-1:0];
    end

    // one shared signed multiplier, operands picked by the current command
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MUL_INIT:
            begin
                mul_a = $signed({1'b0, span_p1});
                mul_b = $signed({2'b00, MS_PER_S});
            end
            DP_MAP_MUL1:
            begin
                mul_a = MUL_W'(cur_reg) - MUL_W'(cfg.min_angle);
                mul_b = $signed({2'b00, cfg.max_pulse}) - $signed({2'b00, cfg.min_pulse});
            end
            DP_MAP_MUL2:
            begin
                mul_a = $signed({2'b00, cfg.min_pulse});
                mul_b = MUL_W'(den);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        // dist > span  <=>  v*e >= (span+1)*1000
        snap = CMP_W'(acc_reg) >= CMP_W'($unsigned(prod_reg));

        // below the snap point the product stays under 2^26
        recip_p = (DIVX_W+RECIP_W)'(acc_reg[DIVX_W-1:0])
                * (DIVX_W+RECIP_W)'(MS_RECIP);
        dist_q  = recip_p[RECIP_SH +: PULSE_W];

        num_hi   = num_reg[MPROD_W-1:16];
        num_neg  = num_reg[MPROD_W-1];
        num_over = num_hi >= (MPROD_W-16)'(den_abs);

        trial    = {rem_reg, quo_reg[PULSE_W-1]};
        fits     = trial >= {1'b0, dvsr_reg};
        rem_step = fits ? PULSE_W'(trial - {1'b0, dvsr_reg}) : trial[PULSE_W-1:0];

        q_ext    = $signed({1'b0, quo_reg});
        move_val = goal_up ? (ANGLE_W+1)'(start_reg) + q_ext
                           : (ANGLE_W+1)'(start_reg) - q_ext;
    end

    assign stat.snap        = snap;
    assign stat.map_special = (den == '0) || num_neg || num_over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= HOME_RST;
            cur_reg     <= HOME_RST;
            goal_reg    <= HOME_RST;
            elapsed_reg <= '0;
            vel_reg     <= MAX_VEL_RST;
        end
        else
        begin
            case (cmd.op)
                DP_ACCEPT:
                begin
                    unique case (op_t'(op))
                        OP_TICK:     elapsed_reg <= elapsed_sat;
                        OP_TARGET:
                        begin
                            start_reg   <= cur_reg;
                            elapsed_reg <= '0;
                            goal_reg    <= target_angle_in;
                        end
                        OP_VELOCITY: vel_reg <= vel_clamped;
                        OP_HOLD:     ;
                    endcase
                end
                DP_CMP:
                begin
                    if (snap)
                    begin
                        cur_reg   <= goal_reg;
                        start_reg <= goal_reg;
                    end
                end
                DP_MOVE: cur_reg <= move_val[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_MUL_INIT:
            begin
                acc_reg    <= '0;
                mcand_reg  <= PROD_W'(elapsed_reg);
                mplier_reg <= vel_reg;
                prod_reg   <= mul_p;
            end
            DP_MUL_STEP:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            DP_CMP: quo_reg <= dist_q;
            DP_DIV_STEP:
            begin
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[PULSE_W-2:0], fits};
            end
            DP_MAP_MUL1: prod_reg <= mul_p;
            DP_MAP_MUL2:
            begin
                num_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            DP_MAP_SUM: num_reg <= num_reg + prod_reg;
            DP_MAP_FIX:
            begin
                if (den[ANGLE_W])
                    num_reg <= -num_reg;
            end
            DP_MAP_EVAL:
            begin
                if (den == '0)
                    pulse_tmp_reg <= cfg.min_pulse;
                else if (num_neg)
                    pulse_tmp_reg <= '0;
                else if (num_over)
                    pulse_tmp_reg <= '1;
                else
                begin
                    rem_reg  <= num_reg[31:16];
                    quo_reg  <= num_reg[15:0];
                    dvsr_reg <= den_abs;
                end
            end
            DP_PULSE: pulse_tmp_reg <= quo_reg;
            DP_RESULT:
            begin
                pulse_out_reg <= pulse_tmp_reg;
                angle_out_reg <= cur_reg;
                at_tgt_reg    <= (cur_reg == goal_reg);
            end
            default: ;
        endcase
    end

    assign pulse_us  = pulse_out_reg;
    assign angle_now = angle_out_reg;
    assign at_target = at_tgt_reg;

endmodule

// ===== rtl/core/srpg_ctrl.sv =====
`timescale 1ns / 1ps

module srpg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_op,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output srpg_pkg::dp_cmd_t   cmd,
    input  srpg_pkg::dp_stat_t  stat
);
    import srpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_INIT,
        S_MUL_RUN,
        S_CMP,
        S_DIV_RUN,
        S_MOVE,
        S_MAP_MUL1,
        S_MAP_MUL2,
        S_MAP_SUM,
        S_MAP_FIX,
        S_MAP_EVAL,
        S_PULSE,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                rsp_valid_reg;
    logic                out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                        state_reg <= (op_t'(req_op) == OP_TICK) ? S_MUL_INIT : S_MAP_MUL1;
                end
                S_MUL_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MUL_RUN;
                end
                S_MUL_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEPS - 1))
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    step_reg  <= '0;
                    state_reg <= stat.snap ? S_MAP_MUL1 : S_MOVE;
                end
                S_DIV_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEPS - 1))
                        state_reg <= S_PULSE;
                end
                S_MOVE:     state_reg <= S_MAP_MUL1;
                S_MAP_MUL1: state_reg <= S_MAP_MUL2;
                S_MAP_MUL2: state_reg <= S_MAP_SUM;
                S_MAP_SUM:  state_reg <= S_MAP_FIX;
                S_MAP_FIX:  state_reg <= S_MAP_EVAL;
                S_MAP_EVAL:
                begin
                    step_reg  <= '0;
                    state_reg <= stat.map_special ? S_DONE : S_DIV_RUN;
                end
                S_PULSE:    state_reg <= S_DONE;
                S_DONE:
                begin
                    // wait for the output register to drain
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:     cmd.op = req_valid ? DP_ACCEPT : DP_NONE;
            S_MUL_INIT: cmd.op = DP_MUL_INIT;
            S_MUL_RUN:  cmd.op = DP_MUL_STEP;
            S_CMP:      cmd.op = DP_CMP;
            S_DIV_RUN:  cmd.op = DP_DIV_STEP;
            S_MOVE:     cmd.op = DP_MOVE;
            S_MAP_MUL1: cmd.op = DP_MAP_MUL1;
            S_MAP_MUL2: cmd.op = DP_MAP_MUL2;
            S_MAP_SUM:  cmd.op = DP_MAP_SUM;
            S_MAP_FIX:  cmd.op = DP_MAP_FIX;
            S_MAP_EVAL: cmd.op = DP_MAP_EVAL;
            S_PULSE:    cmd.op = DP_PULSE;
            S_DONE:     cmd.op = out_free ? DP_RESULT : DP_NONE;
            default:    cmd.op = DP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/servo_ramp_pulse_generator.sv =====
// Steps: a target, velocity or hold word maps the angle to a pulse, dividing unless the pulse
// saturates or the range is empty; a tick first multiplies, compares and, if not snapped, moves.
// Throughput: one word at a time; the next is taken the cycle after the result is loaded,
// and a result left waiting at the output holds the block in its last step.
// Reset: rst_n async low; config and motion state to defaults, angles home, velocity at max.
`timescale 1ns / 1ps

module servo_ramp_pulse_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_en,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    srpg_req_if.sink                          req,
    srpg_rsp_if.source                        rsp
);
    import srpg_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    srpg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    srpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_op    (req.op),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    srpg_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg             (cfg),
        .op              (req.op),
        .delta_ms        (req.delta_ms),
        .target_angle_in (req.target_angle_in),
        .velocity_in     (req.velocity_in),
        .pulse_us        (rsp.pulse_us),
        .angle_now       (rsp.angle_now),
        .at_target       (rsp.at_target)
    );

endmodule

// ===== rtl/core/srpg_checker.sv =====
`timescale 1ns / 1ps
`include "servo_ramp_pulse_generator_macros.svh"

module srpg_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input srpg_pkg::pulse_t    pulse_us,
    input srpg_pkg::angle_t    angle_now,
    input logic                at_target
);

    // a stalled result word holds
    `SRPG_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(pulse_us) && $stable(angle_now) && $stable(at_target))

    // one word in flight: busy right after a word is taken
    `SRPG_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // a new result only appears out of a busy cycle
    `SRPG_HOLDS(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready))

endmodule

bind servo_ramp_pulse_generator srpg_checker u_srpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .pulse_us  (rsp.pulse_us),
    .angle_now (rsp.angle_now),
    .at_target (rsp.at_target)
);
